// ----- sv/pwcs_pkg.sv -----
// Shared types and constants for the packet word chunk segmenter.
// No dependencies; imported by every module of the block.
package pwcs_pkg;

   // Field widths fixed by the interface
   localparam int unsigned BYTES_W = 13;
   localparam int unsigned PRIO_W  = 3;
   localparam int unsigned TAG_W   = 16;
   localparam int unsigned SEQ_W   = 6;
   localparam int unsigned BW_W    = 9;
   localparam int unsigned CHUNK_W = 5;
   localparam int unsigned CHB_W   = BW_W + CHUNK_W;
   localparam int unsigned CSR_IDX_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_BYTES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_CHUNK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LATER_CHUNK = 2'd2;

   // Reset values of the registers
   localparam logic [BW_W-1:0]    WORD_BYTES_RST  = 9'd128;
   localparam logic [CHUNK_W-1:0] FIRST_CHUNK_RST = 5'd2;
   localparam logic [CHUNK_W-1:0] LATER_CHUNK_RST = 5'd1;

   // Effective configuration, zero values already mapped to one
   typedef struct packed {
      logic [BW_W-1:0]    word_bytes;
      logic [CHUNK_W-1:0] first_chunk;
      logic [CHUNK_W-1:0] later_chunk;
   } cfg_type;

   // Result of one pass through the byte unit
   typedef struct packed {
      logic               last_word;
      logic               fits_chunk;
      logic [BW_W-1:0]    valid_bytes;
      logic [BYTES_W-1:0] bytes_next;
   } step_type;

endpackage

// ----- sv/packet_word_chunk_segmenter_core.sv -----
// Packet to bus-word segmenter. A packet descriptor is taken when req_stall is low and
// the block then emits one bus word per cycle while rsp_stall is low: req_stall stays high
// until a packet of N words has emitted its final word (N up to MAX_WORDS, 64 by
// default); a zero-length packet emits nothing.
// The rate is set by the single byte unit that subtracts one bus width per word. A
// registered result stage holds each word under rsp_stall, and the next packet is taken
// while the final word still waits there. The user must change settings only while
// idle; the block itself does not enforce it.
module packet_word_chunk_segmenter_core #(
   parameter int unsigned MAX_WORDS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pwcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pwcs_pkg::BW_W-1:0]         csr_wdata,
   // packet descriptor channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pwcs_pkg::BYTES_W-1:0]      req_packet_bytes,
   input  logic [pwcs_pkg::PRIO_W-1:0]       req_packet_priority,
   input  logic [pwcs_pkg::TAG_W-1:0]        req_packet_tag,
   // bus word channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pwcs_pkg::TAG_W-1:0]        rsp_word_tag,
   output logic [pwcs_pkg::PRIO_W-1:0]       rsp_word_priority,
   output logic [pwcs_pkg::SEQ_W-1:0]        rsp_word_seq,
   output logic [pwcs_pkg::BW_W-1:0]         rsp_valid_bytes,
   output logic                              rsp_sop_flag,
   output logic                              rsp_eop_flag,
   output logic                              rsp_chunk_first,
   output logic                              rsp_chunk_last,
   output logic                              rsp_run_last
);
   import pwcs_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_WORDS);
   localparam logic        ST_IDLE = 1'b0;
   localparam logic        ST_RUN  = 1'b1;

   cfg_type  cfg;
   step_type step;

   // sequencer state
   logic               state_ff, state_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [PRIO_W-1:0]  prio_ff, prio_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CHUNK_W-1:0] pos_ff, pos_in;
   logic               first_ff, first_in;
   logic               ceop_ff, ceop_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [TAG_W-1:0]   out_tag_ff, out_tag_in;
   logic [PRIO_W-1:0]  out_prio_ff, out_prio_in;
   logic [SEQ_W-1:0]   out_seq_ff, out_seq_in;
   logic [BW_W-1:0]    out_vb_ff, out_vb_in;
   logic               out_sop_ff, out_sop_in;
   logic               out_eop_ff, out_eop_in;
   logic               out_cfirst_ff, out_cfirst_in;
   logic               out_clast_ff, out_clast_in;
   logic               out_rlast_ff, out_rlast_in;

   logic               take_req;
   logic               emit;
   logic [CHUNK_W-1:0] size;
   logic               chunk_start;
   logic               chunk_end;
   logic               chunk_eop;
   logic               run_last;

   pwcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pwcs_byte_unit u_byte (
      .bytes_left (bytes_ff),
      .word_bytes (cfg.word_bytes),
      .chunk_size (size),
      .step       (step)
   );

   assign req_stall = (state_ff == ST_RUN);
   assign take_req  = req_valid && !req_stall;
   // Produce a word when running and the result register frees up
   assign emit      = (state_ff == ST_RUN) && (!out_valid_ff || !rsp_stall);

   // Chunk position decode
   assign size        = first_ff ? cfg.first_chunk : cfg.later_chunk;
   assign chunk_start = (pos_ff == '0);
   assign chunk_end   = chunk_start ? (size == CHUNK_W'(1)) : (pos_ff == size - CHUNK_W'(1));
   assign chunk_eop   = chunk_start ? step.fits_chunk : ceop_ff;
   assign run_last    = step.last_word || (cnt_ff == CNT_W'(MAX_WORDS - 1));

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      bytes_in = bytes_ff;
      prio_in  = prio_ff;
      tag_in   = tag_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      first_in = first_ff;
      ceop_in  = ceop_ff;
      if (take_req) begin
         state_in = (req_packet_bytes != '0) ? ST_RUN : ST_IDLE;
         bytes_in = req_packet_bytes;
         prio_in  = req_packet_priority;
         tag_in   = req_packet_tag;
         cnt_in   = '0;
         pos_in   = '0;
         first_in = 1'b1;
         ceop_in  = 1'b0;
      end else if (emit) begin
         bytes_in = step.bytes_next;
         cnt_in   = cnt_ff + CNT_W'(1);
         ceop_in  = chunk_eop;
         if (chunk_end) begin
            pos_in   = '0;
            first_in = 1'b0;
         end else begin
            pos_in = pos_ff + CHUNK_W'(1);
         end
         if (run_last) begin
            state_in = ST_IDLE;
         end
      end
   end

   // Result register next value: load on emit, drop on an accepted beat
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_tag_in    = out_tag_ff;
      out_prio_in   = out_prio_ff;
      out_seq_in    = out_seq_ff;
      out_vb_in     = out_vb_ff;
      out_sop_in    = out_sop_ff;
      out_eop_in    = out_eop_ff;
      out_cfirst_in = out_cfirst_ff;
      out_clast_in  = out_clast_ff;
      out_rlast_in  = out_rlast_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_tag_in    = tag_ff;
         out_prio_in   = prio_ff;
         out_seq_in    = SEQ_W'(cnt_ff);
         out_vb_in     = step.valid_bytes;
         out_sop_in    = first_ff;
         out_eop_in    = chunk_eop || step.last_word;
         out_cfirst_in = chunk_start;
         out_clast_in  = chunk_end || step.last_word;
         out_rlast_in  = run_last;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bytes_ff      <= bytes_in;
      prio_ff       <= prio_in;
      tag_ff        <= tag_in;
      cnt_ff        <= cnt_in;
      pos_ff        <= pos_in;
      first_ff      <= first_in;
      ceop_ff       <= ceop_in;
      out_tag_ff    <= out_tag_in;
      out_prio_ff   <= out_prio_in;
      out_seq_ff    <= out_seq_in;
      out_vb_ff     <= out_vb_in;
      out_sop_ff    <= out_sop_in;
      out_eop_ff    <= out_eop_in;
      out_cfirst_ff <= out_cfirst_in;
      out_clast_ff  <= out_clast_in;
      out_rlast_ff  <= out_rlast_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_word_tag      = out_tag_ff;
   assign rsp_word_priority = out_prio_ff;
   assign rsp_word_seq      = out_seq_ff;
   assign rsp_valid_bytes   = out_vb_ff;
   assign rsp_sop_flag      = out_sop_ff;
   assign rsp_eop_flag      = out_eop_ff;
   assign rsp_chunk_first   = out_cfirst_ff;
   assign rsp_chunk_last    = out_clast_ff;
   assign rsp_run_last      = out_rlast_ff;

   // A running packet always has bytes left to cut
   a_run_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (bytes_ff != '0))
      else $error("running with no bytes left");

   // Every emitted word carries at least one byte
   a_word_nonempty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_vb_ff != '0))
      else $error("empty bus word");

   // Emitting the final word returns the sequencer to idle
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit && run_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer still running after final word");

   // A word that is not final is followed by more work
   a_more_after_word: assert property (@(posedge clock) disable iff (reset)
      (emit && !run_last) |=> (state_ff == ST_RUN))
      else $error("sequencer stopped before final word");

endmodule

// ----- sv/pwcs_csr.sv -----
// Configuration registers of the segmenter: bus width and chunk sizes.
// Depends on pwcs_pkg; presents the effective settings as a cfg_type.
module pwcs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pwcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwcs_pkg::BW_W-1:0]        csr_wdata,
   output pwcs_pkg::cfg_type                cfg
);
   import pwcs_pkg::*;

   logic [BW_W-1:0]    word_bytes_ff;
   logic [CHUNK_W-1:0] first_chunk_ff;
   logic [CHUNK_W-1:0] later_chunk_ff;

   // Always take a write beat
   assign csr_ready = 1'b1;

   // Update the addressed register; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         word_bytes_ff  <= WORD_BYTES_RST;
         first_chunk_ff <= FIRST_CHUNK_RST;
         later_chunk_ff <= LATER_CHUNK_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WORD_BYTES:  word_bytes_ff  <= csr_wdata;
            CSR_FIRST_CHUNK: first_chunk_ff <= csr_wdata[CHUNK_W-1:0];
            CSR_LATER_CHUNK: later_chunk_ff <= csr_wdata[CHUNK_W-1:0];
            default: ;
         endcase
      end
   end

   // Map zero settings to one
   always_comb begin
      cfg.word_bytes  = (word_bytes_ff == '0)  ? BW_W'(1)    : word_bytes_ff;
      cfg.first_chunk = (first_chunk_ff == '0) ? CHUNK_W'(1) : first_chunk_ff;
      cfg.later_chunk = (later_chunk_ff == '0) ? CHUNK_W'(1) : later_chunk_ff;
   end

endmodule

// ----- sv/pwcs_byte_unit.sv -----
// Shared byte unit: one subtract and compare of remaining bytes per word.
// Depends on pwcs_pkg; used once per emitted word by the sequencer.
module pwcs_byte_unit (
   input  logic [pwcs_pkg::BYTES_W-1:0] bytes_left,
   input  logic [pwcs_pkg::BW_W-1:0]    word_bytes,
   input  logic [pwcs_pkg::CHUNK_W-1:0] chunk_size,
   output pwcs_pkg::step_type           step
);
   import pwcs_pkg::*;

   logic [CHB_W-1:0]   chunk_bytes;
   logic [BYTES_W:0]   bytes_ext;
   logic [BYTES_W:0]   width_ext;

   assign bytes_ext   = {1'b0, bytes_left};
   assign width_ext   = (BYTES_W+1)'(word_bytes);
   // Bytes a whole chunk of this size carries
   assign chunk_bytes = CHB_W'(chunk_size) * CHB_W'(word_bytes);

   // Decide the final word and advance the byte count by one bus word
   always_comb begin
      step.last_word   = (bytes_ext <= width_ext);
      step.fits_chunk  = (CHB_W'(bytes_left) <= chunk_bytes);
      step.valid_bytes = step.last_word ? bytes_left[BW_W-1:0] : word_bytes;
      step.bytes_next  = step.last_word ? '0 : BYTES_W'(bytes_ext - width_ext);
   end

endmodule

// ----- tb/packet_word_chunk_segmenter_core_tb.sv -----
// Self-checking testbench for packet_word_chunk_segmenter_core.
// Needs pwcs_pkg and the core. It predicts every bus word of each accepted
// packet and checks the words in order, with random idling on both channels.
module packet_word_chunk_segmenter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pwcs_pkg::*;

   localparam int unsigned WORD_LIMIT  = 64;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned TAIL_CYCLES = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [BYTES_W-1:0] nbytes;
      logic [PRIO_W-1:0]  prio;
      logic [TAG_W-1:0]   tag;
   } packet_type;

   typedef struct {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [SEQ_W-1:0]  seq;
      logic [BW_W-1:0]   vbytes;
      logic              sop;
      logic              eop;
      logic              cfirst;
      logic              clast;
      logic              rlast;
   } bus_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BW_W-1:0]      csr_wdata = '0;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [BYTES_W-1:0] req_packet_bytes = '0;
   logic [PRIO_W-1:0]  req_packet_priority = '0;
   logic [TAG_W-1:0]   req_packet_tag = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [TAG_W-1:0]   rsp_word_tag;
   logic [PRIO_W-1:0]  rsp_word_priority;
   logic [SEQ_W-1:0]   rsp_word_seq;
   logic [BW_W-1:0]    rsp_valid_bytes;
   logic               rsp_sop_flag;
   logic               rsp_eop_flag;
   logic               rsp_chunk_first;
   logic               rsp_chunk_last;
   logic               rsp_run_last;

   // shadow of the configuration registers
   logic [BW_W-1:0]    word_bytes_cfg  = WORD_BYTES_RST;
   logic [CHUNK_W-1:0] first_chunk_cfg = FIRST_CHUNK_RST;
   logic [CHUNK_W-1:0] later_chunk_cfg = LATER_CHUNK_RST;

   packet_type   packets_waiting[$];
   bus_word_type words_due[$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   bit no_gaps = 1'b0;

   packet_word_chunk_segmenter_core #(.MAX_WORDS(WORD_LIMIT)) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_packet_bytes(req_packet_bytes),
      .req_packet_priority(req_packet_priority),
      .req_packet_tag(req_packet_tag),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word_tag(rsp_word_tag),
      .rsp_word_priority(rsp_word_priority),
      .rsp_word_seq(rsp_word_seq),
      .rsp_valid_bytes(rsp_valid_bytes),
      .rsp_sop_flag(rsp_sop_flag),
      .rsp_eop_flag(rsp_eop_flag),
      .rsp_chunk_first(rsp_chunk_first),
      .rsp_chunk_last(rsp_chunk_last),
      .rsp_run_last(rsp_run_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cut one packet into bus words and queue them as expected beats
   task automatic segment_packet(input logic [BYTES_W-1:0] nbytes,
                                 input logic [PRIO_W-1:0] prio,
                                 input logic [TAG_W-1:0] tag);
      int unsigned left, bw, fc, lc, size, pos, n;
      bit in_first, chunk_eop;
      bus_word_type w;
      left = nbytes;
      bw = (word_bytes_cfg == 0) ? 1 : word_bytes_cfg;
      fc = (first_chunk_cfg == 0) ? 1 : first_chunk_cfg;
      lc = (later_chunk_cfg == 0) ? 1 : later_chunk_cfg;
      in_first = 1'b1;
      chunk_eop = 1'b0;
      pos = 0;
      n = 0;
      while (left > 0 && n < WORD_LIMIT) begin
         size = in_first ? fc : lc;
         w.tag = tag;
         w.prio = prio;
         w.seq = SEQ_W'(n);
         w.sop = in_first;
         w.cfirst = 1'b0;
         w.clast = 1'b0;
         // advance the position inside the current chunk
         if (pos == 0) begin
            w.cfirst = 1'b1;
            chunk_eop = (left <= size * bw);
            if (size == 1) begin
               w.clast = 1'b1;
               in_first = 1'b0;
            end else begin
               pos = 1;
            end
         end else if (pos == size - 1) begin
            w.clast = 1'b1;
            in_first = 1'b0;
            pos = 0;
         end else begin
            pos++;
         end
         w.eop = chunk_eop;
         // the final word carries the remainder and closes everything
         if (left <= bw) begin
            w.vbytes = BW_W'(left);
            w.clast = 1'b1;
            w.eop = 1'b1;
            left = 0;
         end else begin
            w.vbytes = BW_W'(bw);
            left -= bw;
         end
         w.rlast = (left == 0) || (n == WORD_LIMIT - 1);
         words_due.push_back(w);
         n++;
      end
   endtask

   function automatic void check_field(input string name, input logic [TAG_W-1:0] want,
                                       input logic [TAG_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Packet driver: predict on each accepted beat, then present the next one
   always @(posedge clock) begin : packet_driver
      packet_type p;
      bit gap;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            segment_packet(req_packet_bytes, req_packet_priority, req_packet_tag);
         if (!req_valid || !req_stall) begin
            gap = !no_gaps && ($urandom_range(99) < 16);
            if (packets_waiting.size() != 0 && !gap) begin
               p = packets_waiting.pop_front();
               req_valid <= 1'b1;
               req_packet_bytes <= p.nbytes;
               req_packet_priority <= p.prio;
               req_packet_tag <= p.tag;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Word monitor: check each accepted beat against the oldest expectation
   always @(posedge clock) begin : word_monitor
      bus_word_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (words_due.size() == 0) begin
               $error("unexpected word: tag %0d seq %0d", rsp_word_tag, rsp_word_seq);
               mismatches++;
            end else begin
               w = words_due.pop_front();
               check_field("word_tag", w.tag, rsp_word_tag);
               check_field("word_priority", w.prio, rsp_word_priority);
               check_field("word_seq", w.seq, rsp_word_seq);
               check_field("valid_bytes", w.vbytes, rsp_valid_bytes);
               check_field("sop_flag", w.sop, rsp_sop_flag);
               check_field("eop_flag", w.eop, rsp_eop_flag);
               check_field("chunk_first", w.cfirst, rsp_chunk_first);
               check_field("chunk_last", w.clast, rsp_chunk_last);
               check_field("run_last", w.rlast, rsp_run_last);
            end
         end
         rsp_stall <= !no_gaps && ($urandom_range(99) < 16);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("packet_word_chunk_segmenter_core_tb: done, errors");
         $finish;
      end
   end

   // Call right after a rising edge; leaves csr_valid high for the next write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BW_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WORD_BYTES:  word_bytes_cfg = data;
         CSR_FIRST_CHUNK: first_chunk_cfg = data[CHUNK_W-1:0];
         CSR_LATER_CHUNK: later_chunk_cfg = data[CHUNK_W-1:0];
         default: ;
      endcase
   endtask

   // Write all registers; chunk writes carry junk above the chunk field
   task automatic configure(input int unsigned bw, input int unsigned fc, input int unsigned lc);
      @(posedge clock);
      write_reg(CSR_WORD_BYTES, BW_W'(bw));
      write_reg(CSR_FIRST_CHUNK, {4'($urandom_range(15)), CHUNK_W'(fc)});
      write_reg(CSR_LATER_CHUNK, {4'($urandom_range(15)), CHUNK_W'(lc)});
      write_reg(CSR_SPARE, BW_W'($urandom));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Hold until the block has drained, then give a trailing zero-length
   // packet time to finish
   task automatic settle();
      @(negedge clock);
      while (packets_waiting.size() != 0 || req_valid || words_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic add_packet(input int unsigned nbytes, input int unsigned prio,
                             input int unsigned tag);
      packet_type p;
      p.nbytes = BYTES_W'(nbytes);
      p.prio = PRIO_W'(prio);
      p.tag = TAG_W'(tag);
      packets_waiting.push_back(p);
   endtask

   // Mostly legal lengths, some empty, some short, some beyond the nominal range
   function automatic int unsigned pick_length();
      int unsigned bw, r;
      bw = (word_bytes_cfg == 0) ? 1 : word_bytes_cfg;
      r = $urandom_range(15);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(8191, 4097);
      if (r < 6) return $urandom_range(3 * bw, 1);
      return $urandom_range(4096, 1);
   endfunction

   task automatic add_random(input int unsigned count);
      repeat (count) add_packet(pick_length(), $urandom_range(7), $urandom_range(16'hffff));
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: empty, single byte, word boundaries, longest packets
      add_packet(0, 0, 0);
      add_packet(1, 7, 16'hffff);
      add_packet(128, 3, 16'h1234);
      add_packet(129, 4, 16'h8000);
      add_packet(256, 5, 16'h00ff);
      add_packet(300, 6, 16'ha5a5);
      add_packet(4096, 7, 16'hffff);
      add_packet(8191, 1, 16'h0001);
      add_random(60);
      settle();

      // narrowest nominal bus: exactly the word limit, then one byte past it
      configure(64, 1, 1);
      add_packet(4096, 0, 16'h0f0f);
      add_packet(4097, 7, 16'hf0f0);
      add_packet(64, 2, 16'h7fff);
      add_random(60);
      settle();

      // widest nominal bus with the largest nominal chunks
      configure(256, 16, 16);
      add_packet(4096, 5, 16'h5555);
      add_packet(4095, 2, 16'haaaa);
      add_random(60);
      settle();

      // zero registers fall back to one byte and one-word chunks
      configure(0, 0, 0);
      add_packet(1, 1, 16'h0100);
      add_packet(64, 6, 16'h0200);
      add_packet(65, 3, 16'h0300);
      add_random(40);
      settle();

      // all-ones registers: bus wider than nominal, oversized chunks
      configure(511, 31, 31);
      add_packet(511, 4, 16'h1111);
      add_packet(512, 0, 16'h2222);
      add_packet(8191, 7, 16'h3333);
      add_random(40);
      settle();

      configure(64, 16, 2);
      add_random(50);
      settle();

      configure($urandom_range(256, 64), $urandom_range(16, 1), $urandom_range(16, 1));
      add_random(45);
      settle();

      // back-to-back traffic with no idling on either side
      configure($urandom_range(256, 64), $urandom_range(16, 1), $urandom_range(16, 1));
      no_gaps = 1'b1;
      add_random(45);
      settle();
      no_gaps = 1'b0;

      // pause the sender mid-phase until every word is out
      configure($urandom_range(256, 64), $urandom_range(16, 1), $urandom_range(16, 1));
      add_random(20);
      settle();
      add_random(25);
      settle();

      if (mismatches == 0)
         $display("packet_word_chunk_segmenter_core_tb: done, clean");
      else
         $display("packet_word_chunk_segmenter_core_tb: done, errors");
      $finish;
   end

endmodule
